// File: rtl/core/smq16_pkg.sv
`default_nettype none
package smq16_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAG_W     = 31;
  localparam int QW        = MAG_W + FRAC_BITS;
  localparam int PROD_W    = 2 * MAG_W;

  localparam logic [MAG_W-1:0] MAG_MAX    = {MAG_W{1'b1}};
  localparam logic [7:0]       EXP_ALL1   = 8'hff;
  localparam int               CONV_SHIFT = 127 + 23 - FRAC_BITS;

  typedef enum logic [1:0] {
    ACT_MUL  = 2'd0,
    ACT_DIV  = 2'd1,
    ACT_CONV = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic             vld;
    action_t          act;
    logic             sign;
    logic [31:0]      word;
    status_t          status;
    logic [MAG_W:0]   rem;
    logic [QW-1:0]    dvd;
    logic [QW-1:0]    quo;
    logic [MAG_W-1:0] mb;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/core/sign_magnitude_q16_16_arith_unit_core.sv
// Sign-magnitude Q16.16 arithmetic unit: multiply, divide, float32 to fixed.
// Input channel in_valid/in_ready carries in_action, in_operand_a and
// in_operand_b; result channel out_valid/out_ready carries out_result_word and
// out_status. Every input word yields exactly one result word, in order.
// Stages in order: an input register, a stage that forms the 31x31
// product and the float conversion, one restoring-division stage per
// quotient bit (QW = 31 + fraction bits), and the output register.
// Multiply and convert ride the same stages so results stay in order.
// Throughput is one word per cycle. The whole pipeline advances together
// whenever the output register is empty or being taken; when the receiver
// holds out_ready low with a result waiting, every stage holds and in_ready
// drops, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; the block accepts
// words on the first cycle after reset is released.
`default_nettype none
module sign_magnitude_q16_16_arith_unit_core
  import smq16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_result_word,
  output logic [1:0]       out_status
);

  logic en;

  logic        in_vld_r;
  action_t     in_act_r;
  logic [31:0] in_a_r;
  logic [31:0] in_b_r;

  stage_t              pre_r, pre_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  stage_t              dv_r   [QW];
  stage_t              dv_nxt [QW];

  logic        out_vld_r;
  logic [31:0] out_word_r, out_word_nxt;
  status_t     out_st_r, out_st_nxt;

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_valid;
    end
    if (en) begin
      in_act_r <= action_t'(in_action);
      in_a_r   <= in_operand_a;
      in_b_r   <= in_operand_b;
    end
  end

  // product and float conversion
  logic [7:0]       efield;
  logic [23:0]      mant;
  logic [8:0]       ex;
  logic signed [9:0] sh;
  logic [9:0]       nsh;
  logic [63:0]      lmag;
  logic [31:0]      cword;
  status_t          cst;

  always_comb begin
    efield = in_a_r[30:23];
    mant   = {(efield != 8'd0), in_a_r[22:0]};
    ex     = (efield == 8'd0) ? 9'd1 : {1'b0, efield};
    sh     = $signed({1'b0, ex}) - 10'(CONV_SHIFT);
    nsh    = 10'(-sh);
    lmag   = {40'd0, mant} << sh[4:0];
    cword  = 32'd0;
    cst    = ST_OK;
    if (efield == EXP_ALL1) begin
      cword = {in_a_r[31], MAG_MAX};
      cst   = ST_SAT;
    end else if (mant == 24'd0) begin
      cword = 32'd0;
    end else if (sh >= 0) begin
      if (sh > 10'sd31 || lmag > {33'd0, MAG_MAX}) begin
        cword = {in_a_r[31], MAG_MAX};
        cst   = ST_SAT;
      end else begin
        cword = {in_a_r[31], lmag[MAG_W-1:0]};
      end
    end else if (nsh >= 10'd32) begin
      cword = {in_a_r[31], {MAG_W{1'b0}}};
    end else begin
      cword = {in_a_r[31], 7'd0, mant >> nsh[4:0]};
    end

    prod_nxt        = PROD_W'(in_a_r[MAG_W-1:0]) * PROD_W'(in_b_r[MAG_W-1:0]);
    pre_nxt.vld     = in_vld_r;
    pre_nxt.act     = in_act_r;
    pre_nxt.sign    = in_a_r[31] ^ in_b_r[31];
    pre_nxt.word    = (in_act_r == ACT_CONV) ? cword : 32'd0;
    pre_nxt.status  = (in_act_r == ACT_CONV) ? cst : ST_OK;
    pre_nxt.rem     = '0;
    pre_nxt.dvd     = {in_a_r[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    pre_nxt.quo     = '0;
    pre_nxt.mb      = in_b_r[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.vld <= 1'b0;
    end else if (en) begin
      pre_r.vld <= pre_nxt.vld;
    end
    if (en) begin
      pre_r.act    <= pre_nxt.act;
      pre_r.sign   <= pre_nxt.sign;
      pre_r.word   <= pre_nxt.word;
      pre_r.status <= pre_nxt.status;
      pre_r.rem    <= pre_nxt.rem;
      pre_r.dvd    <= pre_nxt.dvd;
      pre_r.quo    <= pre_nxt.quo;
      pre_r.mb     <= pre_nxt.mb;
      prod_r       <= prod_nxt;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    stage_t           src;
    logic [MAG_W:0]   trial;
    logic [PROD_W-FRAC_BITS-1:0] mshift;

    if (i == 0) begin : g_first
      assign src = pre_r;
    end else begin : g_rest
      assign src = dv_r[i-1];
    end

    assign mshift = prod_r[PROD_W-1:FRAC_BITS];

    always_comb begin
      dv_nxt[i] = src;
      trial     = {src.rem[MAG_W-1:0], src.dvd[QW-1]};
      dv_nxt[i].dvd = {src.dvd[QW-2:0], 1'b0};
      if (trial >= {1'b0, src.mb}) begin
        dv_nxt[i].rem = trial - {1'b0, src.mb};
        dv_nxt[i].quo = {src.quo[QW-2:0], 1'b1};
      end else begin
        dv_nxt[i].rem = trial;
        dv_nxt[i].quo = {src.quo[QW-2:0], 1'b0};
      end
      if (i == 0 && src.act == ACT_MUL) begin
        if (mshift > (PROD_W-FRAC_BITS)'(MAG_MAX)) begin
          dv_nxt[i].word   = {src.sign, MAG_MAX};
          dv_nxt[i].status = ST_SAT;
        end else begin
          dv_nxt[i].word   = {src.sign, mshift[MAG_W-1:0]};
          dv_nxt[i].status = ST_OK;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i].vld <= 1'b0;
      end else if (en) begin
        dv_r[i].vld <= dv_nxt[i].vld;
      end
      if (en) begin
        dv_r[i].act    <= dv_nxt[i].act;
        dv_r[i].sign   <= dv_nxt[i].sign;
        dv_r[i].word   <= dv_nxt[i].word;
        dv_r[i].status <= dv_nxt[i].status;
        dv_r[i].rem    <= dv_nxt[i].rem;
        dv_r[i].dvd    <= dv_nxt[i].dvd;
        dv_r[i].quo    <= dv_nxt[i].quo;
        dv_r[i].mb     <= dv_nxt[i].mb;
      end
    end
  end

  stage_t last;
  assign last = dv_r[QW-1];

  always_comb begin
    out_word_nxt = last.word;
    out_st_nxt   = last.status;
    if (last.act == ACT_DIV) begin
      if (last.mb == '0) begin
        out_word_nxt = {last.sign, MAG_MAX};
        out_st_nxt   = ST_DIVZ;
      end else if (last.quo[QW-1:MAG_W] != '0) begin
        out_word_nxt = {last.sign, MAG_MAX};
        out_st_nxt   = ST_SAT;
      end else begin
        out_word_nxt = {last.sign, last.quo[MAG_W-1:0]};
        out_st_nxt   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.vld;
    end
    if (en) begin
      out_word_r <= out_word_nxt;
      out_st_r   <= out_st_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_word = out_word_r;
  assign out_status      = out_st_r;

endmodule
`default_nettype wire

// File: rtl/core/smq16_checker.sv
`default_nettype none
module smq16_checker
  import smq16_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result_word,
  input wire logic [1:0]  out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_word))
    else $error("stalled result word changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_RSVD)
    else $error("reserved status code");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SAT || out_status == ST_DIVZ)
      |-> out_result_word[30:0] == MAG_MAX)
    else $error("flagged result not saturated");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind sign_magnitude_q16_16_arith_unit_core smq16_checker u_smq16_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_word (out_result_word),
  .out_status      (out_status)
);
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;
  import smq16_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] SGN = 32'h8000_0000;
  localparam logic [30:0] MMAX = 31'h7fff_ffff;

  typedef struct {
    logic [31:0] word;
    status_t     status;
  } fx_result_t;

  class fx_scoreboard;
    fx_result_t pending[$];
    int         errors;

    function fx_result_t fixed_of_float(logic [31:0] bits);
      fx_result_t r;
      logic [31:0] sgn;
      logic [7:0]  ef;
      logic [23:0] mant;
      int          ex;
      int          sh;
      logic [63:0] mag;
      sgn = bits & SGN;
      ef = bits[30:23];
      mant = {1'b0, bits[22:0]};
      r.status = ST_OK;
      if (ef == 8'hff) begin
        r.word = sgn | {1'b0, MMAX};
        r.status = ST_SAT;
        return r;
      end
      if (ef != 0) begin
        mant[23] = 1'b1;
        ex = int'(ef) - 127;
      end else begin
        ex = -126;
      end
      if (mant == 0) begin
        r.word = '0;
        return r;
      end
      sh = ex - 23 + FRAC_BITS;
      if (sh > 31) begin
        r.word = sgn | {1'b0, MMAX};
        r.status = ST_SAT;
        return r;
      end
      if (sh >= 0) mag = 64'(mant) << sh;
      else if (-sh >= 32) mag = '0;
      else mag = 64'(mant >> (-sh));
      if (mag > 64'(MMAX)) begin
        mag = 64'(MMAX);
        r.status = ST_SAT;
      end
      r.word = sgn | mag[31:0];
      return r;
    endfunction

    function fx_result_t compute(action_t act, logic [31:0] a, logic [31:0] b);
      fx_result_t r;
      logic [31:0] sgn;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] mag;
      sgn = (a ^ b) & SGN;
      ma = 64'(a[30:0]);
      mb = 64'(b[30:0]);
      r.word = '0;
      r.status = ST_OK;
      case (act)
        ACT_MUL, ACT_DIV: begin
          if (act == ACT_DIV && mb == 0) begin
            r.word = sgn | {1'b0, MMAX};
            r.status = ST_DIVZ;
            return r;
          end
          mag = (act == ACT_MUL) ? (ma * mb) >> FRAC_BITS : (ma << FRAC_BITS) / mb;
          if (mag > 64'(MMAX)) begin
            mag = 64'(MMAX);
            r.status = ST_SAT;
          end
          r.word = sgn | mag[31:0];
        end
        ACT_CONV: r = fixed_of_float(a);
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(action_t act, logic [31:0] a, logic [31:0] b);
      pending.push_back(compute(act, a, b));
    endfunction

    function void check_result(logic [31:0] word, logic [1:0] status);
      fx_result_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: actual word %h status %0d", $time, word, status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (word !== e.word) begin
        $display("%0t word mismatch: expected %h actual %h", $time, e.word, word);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t status mismatch: expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_result_word;
  logic [1:0]  out_status;
  int          burst_left = 0;

  fx_scoreboard sb = new();

  sign_magnitude_q16_16_arith_unit_core dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(action_t'(in_action), in_operand_a, in_operand_b);
      if (out_valid && out_ready) sb.check_result(out_result_word, out_status);
    end
  end

  // stall receiver in its own pattern: long open stretches, then choppy ones
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if ((phase / 200) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) < 60);
    end
  end

  task automatic send_word(logic [1:0] act, logic [31:0] a, logic [31:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [31:0] rand_fixed();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 4))
      0: v = v & 32'h8000_ffff;
      1: v = v & 32'h801f_ffff;
      2: v = v & 32'h8000_0000;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 3) != 0) v[30:23] = 8'(108 + $urandom_range(0, 40));
    return v;
  endfunction

  initial begin
    int k;
    logic [1:0] act;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_word(ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(ACT_MUL, 32'h8001_0000, 32'h0001_0000);
    send_word(ACT_MUL, 32'h8000_0000, 32'h8000_0001);
    send_word(ACT_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_word(ACT_DIV, 32'h0001_0000, 32'h0000_0000);
    send_word(ACT_DIV, 32'h8000_0000, 32'h8000_0000);
    send_word(ACT_DIV, 32'h7fff_ffff, 32'h0000_0001);
    send_word(ACT_DIV, 32'h8003_0000, 32'h0002_0000);
    send_word(ACT_DIV, 32'h0000_0001, 32'h7fff_ffff);
    send_word(ACT_CONV, 32'h7f80_0000, 32'h0);
    send_word(ACT_CONV, 32'hff80_0000, 32'hffff_ffff);
    send_word(ACT_CONV, 32'h7fc0_0001, 32'h0);
    send_word(ACT_CONV, 32'h0000_0000, 32'h0);
    send_word(ACT_CONV, 32'h8000_0000, 32'h0);
    send_word(ACT_CONV, 32'h8000_0001, 32'h0);
    send_word(ACT_CONV, 32'h007f_ffff, 32'h0);
    send_word(ACT_CONV, 32'h3f80_0000, 32'h0);
    send_word(ACT_CONV, 32'hc0c0_0000, 32'h0);
    send_word(ACT_CONV, 32'h4700_0000, 32'h0);
    send_word(ACT_CONV, 32'h46ff_fffe, 32'h0);
    send_word(ACT_CONV, 32'h3780_0000, 32'h0);
    send_word(ACT_CONV, 32'hb77f_ffff, 32'h0);
    send_word(ACT_CONV, 32'h7f7f_ffff, 32'h0);
    send_word(ACT_NOP, 32'hffff_ffff, 32'hffff_ffff);
    for (k = 0; k < 1100; k++) begin
      act = ($urandom_range(0, 40) == 0) ? ACT_NOP : 2'($urandom_range(0, 2));
      if (act == ACT_CONV) send_word(act, rand_float(), $urandom());
      else send_word(act, rand_fixed(), ($urandom_range(0, 30) == 0) ? 32'h0 : rand_fixed());
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/smq16_pkg.sv
rtl/core/sign_magnitude_q16_16_arith_unit_core.sv
rtl/core/smq16_checker.sv
tb/sv/tb.sv
